@@ design/psl_pkg.sv @@
// ----------------------------------------------------------------------------
// psl_pkg: shared definitions for the prime sieve list block
// Field widths, default sizes, operation codes, controller states and the
// command and status groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package psl_pkg;

  localparam int LIMIT_BITS_DEF = 16;
  localparam int LIST_DEPTH_DEF = 8192;

  localparam int LIMIT_W = 16;
  localparam int INDEX_W = 13;
  localparam int COUNT_W = 14;
  localparam int VALUE_W = 16;

  localparam int FIRST_PRIME = 2;

  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_PRD,
    ST_PCHK,
    ST_STRIKE,
    ST_SCAN,
    ST_FLUSH,
    ST_LRD,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic init_step;
    logic p_read;
    logic p_next;
    logic strike_start;
    logic strike_step;
    logic clr_v;
    logic scan_step;
    logic list_read;
    logic resp_load;
  } cmd_t;

  typedef struct packed {
    logic v_at_lim;
    logic sq_over;
    logic m_last;
    logic flag;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ design/psl_if.sv @@
// ----------------------------------------------------------------------------
// psl_if: request and response channels of the prime sieve list block
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface psl_req_if import psl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               op;
  logic [LIMIT_W-1:0] limit;
  logic [INDEX_W-1:0] index;

  modport source (output valid, output op, output limit, output index, input ready);
  modport sink   (input valid, input op, input limit, input index, output ready);
endinterface

interface psl_rsp_if import psl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] prime_count;
  logic [VALUE_W-1:0] prime_value;
  logic               valid_res;

  modport source (output valid, output prime_count, output prime_value,
                  output valid_res, input ready);
  modport sink   (input valid, input prime_count, input prime_value,
                  input valid_res, output ready);
endinterface

`default_nettype wire

@@ design/psl_ram.sv @@
// ----------------------------------------------------------------------------
// psl_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds while
// no read is enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module psl_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ design/psl_ctrl.sv @@
// ----------------------------------------------------------------------------
// psl_ctrl: sequencer of the prime sieve list block
// Steps through flag fill, striking of multiples, list collection, list read
// and response hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module psl_ctrl import psl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_op,
  output logic req_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = (req_op == OP_BUILD) ? ST_INIT : ST_LRD;
        end
      end
      ST_INIT: begin
        if (sts.v_at_lim) state_next = ST_PRD;
      end
      ST_PRD: begin
        state_next = sts.sq_over ? ST_SCAN : ST_PCHK;
      end
      ST_PCHK: begin
        state_next = sts.flag ? ST_STRIKE : ST_PRD;
      end
      ST_STRIKE: begin
        if (sts.m_last) state_next = ST_PRD;
      end
      ST_SCAN: begin
        if (sts.v_at_lim) state_next = ST_FLUSH;
      end
      ST_FLUSH: state_next = ST_RESP;
      ST_LRD:   state_next = ST_RESP;
      ST_RESP: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      ST_INIT: cmd.init_step = 1'b1;
      ST_PRD: begin
        cmd.clr_v  = sts.sq_over;
        cmd.p_read = !sts.sq_over;
      end
      ST_PCHK: begin
        cmd.strike_start = sts.flag;
        cmd.p_next       = !sts.flag;
      end
      ST_STRIKE: begin
        cmd.strike_step = 1'b1;
        cmd.p_next      = sts.m_last;
      end
      ST_SCAN:  cmd.scan_step = 1'b1;
      ST_FLUSH: cmd = '0;
      ST_LRD:   cmd.list_read = 1'b1;
      ST_RESP:  cmd.resp_load = sts.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ design/psl_dp.sv @@
// ----------------------------------------------------------------------------
// psl_dp: datapath of the prime sieve list block
// Flag and list memories, sieve counters, prime count and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module psl_dp import psl_pkg::*; #(
  parameter int LIMIT_BITS = LIMIT_BITS_DEF,
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_op,
  input  logic [LIMIT_W-1:0] req_limit,
  input  logic [INDEX_W-1:0] req_index,
  input  cmd_t               cmd,
  output sts_t               sts,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic [COUNT_W-1:0] rsp_prime_count,
  output logic [VALUE_W-1:0] rsp_prime_value,
  output logic               rsp_valid_res
);

  localparam int FLAG_DEPTH = 2 ** LIMIT_BITS;
  localparam int SW  = LIMIT_BITS + 2;
  localparam int LMW = (LIMIT_BITS > LIMIT_W) ? LIMIT_BITS : LIMIT_W;
  localparam int LW  = $clog2(LIST_DEPTH);
  localparam int CW  = $clog2(LIST_DEPTH + 1);
  localparam int KW  = (CW > INDEX_W) ? CW : INDEX_W;
  localparam int PW  = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int VW  = (SW > VALUE_W) ? SW : VALUE_W;

  logic [LIMIT_BITS-1:0] lim;
  logic                  op_q;
  logic [INDEX_W-1:0]    idx_q;
  logic [SW-1:0]         v, p, psq, m;
  logic [SW-1:0]         pend_v;
  logic                  pend;
  logic [CW-1:0]         count;

  logic [LMW-1:0] lim_wide;
  logic [SW-1:0]  lim_ext;
  logic [SW-1:0]  m_sum;
  logic           flag_q;
  logic           flag_we, flag_wd, flag_re;
  logic [LIMIT_BITS-1:0] flag_wa, flag_ra;
  logic           list_we;
  logic [LW-1:0]  list_wa, list_ra;
  logic [VALUE_W-1:0] list_wd, list_q;
  logic [VW-1:0]  pend_wide;
  logic [KW-1:0]  idx_ext, cnt_ext;
  logic [PW-1:0]  cnt_wide;
  logic           hit;

  assign lim_wide = LMW'(req_limit);
  assign lim_ext  = SW'(lim);
  assign m_sum    = m + p;

  assign flag_we = cmd.init_step | cmd.strike_step;
  assign flag_wa = cmd.init_step ? v[LIMIT_BITS-1:0] : m[LIMIT_BITS-1:0];
  assign flag_wd = cmd.init_step ? (v >= SW'(FIRST_PRIME)) : 1'b0;
  assign flag_re = cmd.p_read | cmd.scan_step;
  assign flag_ra = cmd.p_read ? p[LIMIT_BITS-1:0] : v[LIMIT_BITS-1:0];

  psl_ram #(.WIDTH(1), .DEPTH(FLAG_DEPTH)) u_flag_ram (
    .clk     (clk),
    .wr_en   (flag_we),
    .wr_addr (flag_wa),
    .wr_data (flag_wd),
    .rd_en   (flag_re),
    .rd_addr (flag_ra),
    .rd_data (flag_q)
  );

  assign pend_wide = VW'(pend_v);
  assign list_we   = pend && flag_q && (count != CW'(LIST_DEPTH));
  assign list_wa   = count[LW-1:0];
  assign list_wd   = pend_wide[VALUE_W-1:0];
  assign idx_ext   = KW'(idx_q);
  assign cnt_ext   = KW'(count);
  assign list_ra   = idx_ext[LW-1:0];
  assign hit       = (op_q == OP_READ) && (idx_ext < cnt_ext);
  assign cnt_wide  = PW'(count);

  psl_ram #(.WIDTH(VALUE_W), .DEPTH(LIST_DEPTH)) u_list_ram (
    .clk     (clk),
    .wr_en   (list_we),
    .wr_addr (list_wa),
    .wr_data (list_wd),
    .rd_en   (cmd.list_read),
    .rd_addr (list_ra),
    .rd_data (list_q)
  );

  assign sts.v_at_lim = (v == lim_ext);
  assign sts.sq_over  = (psq > lim_ext);
  assign sts.m_last   = (m_sum > lim_ext);
  assign sts.flag     = flag_q;
  assign sts.out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lim   <= lim_wide[LIMIT_BITS-1:0];
      op_q  <= req_op;
      idx_q <= req_index;
      v     <= '0;
      p     <= SW'(FIRST_PRIME);
      psq   <= SW'(FIRST_PRIME * FIRST_PRIME);
    end
    if (cmd.init_step || cmd.scan_step) begin
      v <= v + SW'(1);
    end
    if (cmd.clr_v) begin
      v <= '0;
    end
    if (cmd.p_next) begin
      p   <= p + SW'(1);
      psq <= psq + {p[SW-2:0], 1'b1};
    end
    if (cmd.strike_start) begin
      m <= psq;
    end
    if (cmd.strike_step) begin
      m <= m_sum;
    end
    pend_v <= v;
    if (cmd.resp_load) begin
      rsp_prime_count <= cnt_wide[COUNT_W-1:0];
      rsp_prime_value <= hit ? list_q : '0;
      rsp_valid_res   <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      pend <= cmd.scan_step;
      if (cmd.load && req_op == OP_BUILD) begin
        count <= '0;
      end else if (list_we) begin
        count <= count + CW'(1);
      end
      if (cmd.resp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/prime_sieve_list.sv @@
// ----------------------------------------------------------------------------
// prime_sieve_list: sieve of Eratosthenes with an ascending prime list
// Build fills a flag map up to the limit, strikes composites, and collects the
// primes into a list memory; read returns the prime count and one list entry.
//
//   channel  dir  payload                                 transfer when
//   req      in   op, limit, index                        valid && ready
//   rsp      out  prime_count, prime_value, valid_res     valid && ready
//
// Build runs fill and collection over every value from zero to the limit,
// strikes the multiples of each prime p from p*p up, and checks each
// candidate p with p*p <= limit. The flag memory has a single write port
// and a single read port. Read goes through the list memory's registered read.
// One item is in work at a time; req is ready only between items.
// The response register lets the next item start while a result waits.
// Synchronous reset clears the prime count; memories need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_sieve_list import psl_pkg::*; #(
  parameter int LIMIT_BITS = LIMIT_BITS_DEF,
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  psl_req_if.sink   req,
  psl_rsp_if.source rsp
);

  cmd_t cmd;
  sts_t sts;

  psl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.op),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  psl_dp #(
    .LIMIT_BITS (LIMIT_BITS),
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .req_op          (req.op),
    .req_limit       (req.limit),
    .req_index       (req.index),
    .cmd             (cmd),
    .sts             (sts),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_prime_count (rsp.prime_count),
    .rsp_prime_value (rsp.prime_value),
    .rsp_valid_res   (rsp.valid_res)
  );

endmodule

`default_nettype wire
